>>> hdl/tta_pkg.sv
// shared types and constants of the thresholded temporal average unit
// no dependencies
`default_nettype none

package tta_pkg;

    // defaults for the top level parameters
    localparam int MAX_FRAMES_DEF  = 15;
    localparam int SAMPLE_BITS_DEF = 16;

    // fixed field widths
    localparam int IO_W  = 16;
    localparam int THR_W = 16;
    localparam int PLN_W = 2;
    localparam int CNT_W = 4;
    localparam int IDX_W = 1;

    // register indexes
    localparam logic [IDX_W-1:0] REG_LUMA_THR   = 1'b0;
    localparam logic [IDX_W-1:0] REG_CHROMA_THR = 1'b1;

    // plane code that selects the luma threshold
    localparam logic [PLN_W-1:0] PLANE_LUMA = 2'd0;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic start_div;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic emit;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/tta_div.sv
// restoring divider, one quotient bit per cycle
// uses no package
`default_nettype none

module tta_div #(
    parameter int DVD_W = 20,
    parameter int DVS_W = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic      [DVD_W-1:0] quotient,
    output logic                  done
);

    localparam int ITER_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              done_reg, done_next;
    logic [DVS_W:0]    rem_sh;
    logic [DVS_W:0]    rem_sub;
    logic              ge;

    assign rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_comb begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        iter_next = iter_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            iter_next = ITER_W'(DVD_W);
        end else if (iter_reg != '0) begin
            // shift in next dividend bit, subtract when it fits
            rem_next  = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            dvd_next  = {dvd_reg[DVD_W-2:0], ge};
            iter_next = iter_reg - 1'b1;
            done_next = (iter_reg == ITER_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iter_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            iter_reg <= iter_next;
            done_reg <= done_next;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

>>> hdl/tta_dpath.sv
// datapath: thresholds, group accumulator, divider and output register
// depends on tta_pkg and tta_div
`default_nettype none

module tta_dpath
    import tta_pkg::*;
#(
    parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [THR_W-1:0] cfg_wr_data,
    input  wire logic [IO_W-1:0]  s_sample,
    input  wire logic [PLN_W-1:0] s_plane,
    input  wire logic             s_first,
    input  wire logic             s_last,
    input  wire logic             m_ready,
    output logic                  m_valid,
    output logic      [IO_W-1:0]  m_soft_sample,
    input  wire dp_cmd_t          cmd,
    output dp_stat_t              stat
);

    localparam int SUM_W = SAMPLE_BITS + CNT_W;

    logic [THR_W-1:0]       luma_thr_reg, chroma_thr_reg;
    logic [SAMPLE_BITS-1:0] center_reg, center_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [IO_W-1:0]        out_data_reg;

    logic [SAMPLE_BITS-1:0] smp;
    logic [SAMPLE_BITS-1:0] diff;
    logic [SAMPLE_BITS-1:0] pick;
    logic [THR_W-1:0]       thr;
    logic [SUM_W-1:0]       acc_sum;
    logic [CNT_W-1:0]       acc_count;
    logic [SUM_W-1:0]       dividend;
    logic [SUM_W-1:0]       quotient;
    logic                   div_done;

    assign smp  = s_sample[SAMPLE_BITS-1:0];
    assign thr  = (s_plane == PLANE_LUMA) ? luma_thr_reg : chroma_thr_reg;
    assign diff = (smp > center_reg) ? smp - center_reg : center_reg - smp;
    assign pick = (THR_W'(diff) <= thr) ? smp : center_reg;

    // group state after this beat, before closing on last
    always_comb begin
        center_next = center_reg;
        acc_sum     = sum_reg;
        acc_count   = count_reg;
        if (s_first) begin
            center_next = smp;
            acc_sum     = SUM_W'(smp);
            acc_count   = CNT_W'(1);
        end else if (count_reg != '0 && count_reg < CNT_W'(MAX_FRAMES)) begin
            acc_sum   = sum_reg + SUM_W'(pick);
            acc_count = count_reg + 1'b1;
        end
    end

    assign stat.emit = s_last && (s_first || count_reg != '0);
    assign dividend  = acc_sum + SUM_W'(acc_count >> 1);

    always_comb begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (cmd.accept) begin
            sum_next   = stat.emit ? '0 : acc_sum;
            count_next = stat.emit ? '0 : acc_count;
        end
    end

    tta_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.start_div),
        .dividend (dividend),
        .divisor  (acc_count),
        .quotient (quotient),
        .done     (div_done)
    );

    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (m_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            luma_thr_reg   <= THR_W'(4);
            chroma_thr_reg <= THR_W'(8);
            center_reg     <= '0;
            sum_reg        <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en && cfg_index == REG_LUMA_THR)
                luma_thr_reg <= cfg_wr_data;
            if (cfg_wr_en && cfg_index == REG_CHROMA_THR)
                chroma_thr_reg <= cfg_wr_data;
            if (cmd.accept)
                center_reg <= center_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        if (cmd.load_out)
            out_data_reg <= IO_W'(quotient[SAMPLE_BITS-1:0]);
    end

    assign m_valid       = out_valid_reg;
    assign m_soft_sample = out_data_reg;

endmodule

`default_nettype wire

>>> hdl/tta_ctrl.sv
// controller: input handshake, divider start and result hand-off
// depends on tta_pkg
`default_nettype none

module tta_ctrl
    import tta_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb begin
        state_next    = state_reg;
        cmd.accept    = 1'b0;
        cmd.start_div = 1'b0;
        cmd.load_out  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_valid && ready_reg;
                if (cmd.accept && stat.emit) begin
                    cmd.start_div = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    if (stat.out_free) begin
                        cmd.load_out = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_ready = ready_reg;

endmodule

`default_nettype wire

>>> hdl/thresholded_temporal_average_unit.sv
// top level of the thresholded temporal average unit
// depends on tta_pkg, tta_ctrl, tta_dpath (and tta_div below it)
//
// usage:
// - input channel s_*: one sample beat per frame of a pixel position; the
//   beat with s_first is the center frame, the beat with s_last closes the
//   group. each neighbor adds its own value when it lies within the plane
//   threshold of the center, else the center value
// - result channel m_*: one beat per closed group, the rounded average
//   (sum + count/2) / count
// - cfg port: cfg_wr_en writes cfg_wr_data into register cfg_index
//   (luma threshold, chroma threshold); write only while the unit is idle
// - throughput: the unit stays ready after a beat that does not close a group;
//   a closing beat occupies the unit while the bit-serial divider works through
//   the group sum (SAMPLE_BITS + 4 bits) at one bit per cycle, and while the
//   result waits for a free output register
// - result: the quotient is loaded into the output register once the divider
//   is done and that register is free
// - stall: the result sits in an output register; the next group can be
//   accumulated meanwhile, and only a second result waits for m_ready
// - reset: thresholds return to 4 and 8, any open group is dropped, no
//   result is pending
`default_nettype none

module thresholded_temporal_average_unit
    import tta_pkg::*;
#(
    parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // configuration writes
    input  wire logic             cfg_wr_en,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [THR_W-1:0] cfg_wr_data,
    // sample beats
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [IO_W-1:0]  s_sample,
    input  wire logic [PLN_W-1:0] s_plane,
    input  wire logic             s_first,
    input  wire logic             s_last,
    // result beats
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic      [IO_W-1:0]  m_soft_sample
);

    // command and status between controller and datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // handshake sequencing: accept, divide, hand off result
    tta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // thresholds, accumulator, divider, output register
    tta_dpath #(
        .MAX_FRAMES  (MAX_FRAMES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_sample      (s_sample),
        .s_plane       (s_plane),
        .s_first       (s_first),
        .s_last        (s_last),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_soft_sample (m_soft_sample),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

`default_nettype wire
